### src/vfv_pkg.sv
// Shared types and constants for the voxel face visibility mask unit.
// No dependencies; every file but vfv_ram imports this package.
package vfv_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned OPC_W      = 3;
  localparam int unsigned POS_XZ_W   = 4;
  localparam int unsigned POS_Y_W    = 8;
  localparam int unsigned FLD_CODE_W = 8;
  localparam int unsigned MASK_W     = 6;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER = 1'd1;

  // Face order, shared by the mask bits, neighbor codes and slice stores.
  localparam int unsigned FACE_N    = 0;  // z-1
  localparam int unsigned FACE_S    = 1;  // z+1
  localparam int unsigned FACE_W    = 2;  // x-1
  localparam int unsigned FACE_E    = 3;  // x+1
  localparam int unsigned FACE_B    = 4;  // y-1
  localparam int unsigned FACE_T    = 5;  // y+1
  localparam int unsigned NUM_FACES = 6;
  localparam int unsigned NUM_SIDES = 4;

  typedef enum logic [OPC_W-1:0] {
    OP_CENTRE = 3'd0,
    OP_NORTH  = 3'd1,
    OP_SOUTH  = 3'd2,
    OP_WEST   = 3'd3,
    OP_EAST   = 3'd4,
    OP_QUERY  = 3'd5
  } vfv_op_e;

  typedef struct packed {
    logic [OPC_W-1:0]      opcode;
    logic [POS_XZ_W-1:0]   pos_x;
    logic [POS_Y_W-1:0]    pos_y;
    logic [POS_XZ_W-1:0]   pos_z;
    logic [FLD_CODE_W-1:0] write_code;
  } vfv_in_t;

  typedef struct packed {
    logic [FLD_CODE_W-1:0] voxel_code;
    logic                  is_liquid;
    logic [MASK_W-1:0]     face_mask;
    logic                  liquid_on_top;
  } vfv_out_t;

  // Compare results handed from the classify stage to the mask stage.
  typedef struct packed {
    logic [NUM_FACES-1:0] nb_air;
    logic [NUM_FACES-1:0] nb_water;
    logic                 bot_same;
    logic                 top_same;
    logic                 liquid;
    logic                 y_lo;
    logic                 y_hi;
  } vfv_flags_t;

endpackage

### src/vfv_ram.sv
// Simple dual-port block memory: one write port, one registered read port.
// No dependencies.
module vfv_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/vfv_fetch.sv
// Stage 1: opcode decode, store writes and neighbor reads.
// Depends on vfv_pkg and vfv_ram.
module vfv_fetch import vfv_pkg::*; #(
  parameter int unsigned CHUNK_SIDE = 16,
  parameter int unsigned CHUNK_TALL = 256,
  parameter int unsigned CODE_BITS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,     // stage 1 loads
  input  logic                                 acc_i,    // transaction accepted
  input  vfv_in_t                              in_i,
  output logic                                 query_o,  // accepted in-range query
  output logic [CODE_BITS-1:0]                 blk_code_o,
  output logic [NUM_FACES-1:0][CODE_BITS-1:0]  nb_code_o,
  output logic                                 y_lo_o,
  output logic                                 y_hi_o
);

  localparam int unsigned XW  = $clog2(CHUNK_SIDE);
  localparam int unsigned YW  = $clog2(CHUNK_TALL);
  localparam int unsigned CAW = 2 * XW + YW;
  localparam int unsigned SAW = XW + YW;
  localparam int unsigned NUM_COPIES = NUM_FACES + 1;  // copy 0 reads the voxel itself

  logic [XW-1:0] x, z;
  logic [YW-1:0] y;
  logic          in_range;
  logic          x_lo, x_hi, z_lo, z_hi, y_lo, y_hi;
  logic [CODE_BITS-1:0] wr_code;
  logic          wr_ok;
  logic          cen_we;
  logic [NUM_SIDES-1:0] slc_we;
  logic [CAW-1:0] cen_addr;
  logic [NUM_COPIES-1:0][CAW-1:0] cen_raddr;
  logic [NUM_SIDES-1:0][SAW-1:0]  slc_addr;
  logic [NUM_COPIES-1:0][CODE_BITS-1:0] cen_rd;
  logic [NUM_SIDES-1:0][CODE_BITS-1:0]  slc_rd;
  logic [NUM_FACES-1:0] edge_q;  // x_lo, x_hi, z_lo, z_hi, y_lo, y_hi of the read

  assign x = XW'(in_i.pos_x);
  assign y = YW'(in_i.pos_y);
  assign z = XW'(in_i.pos_z);

  assign in_range = (32'(in_i.pos_x) < CHUNK_SIDE) && (32'(in_i.pos_z) < CHUNK_SIDE) &&
                    (32'(in_i.pos_y) < CHUNK_TALL);
  assign x_lo = (in_i.pos_x == '0);
  assign z_lo = (in_i.pos_z == '0);
  assign y_lo = (in_i.pos_y == '0);
  assign x_hi = (32'(in_i.pos_x) == CHUNK_SIDE - 1);
  assign z_hi = (32'(in_i.pos_z) == CHUNK_SIDE - 1);
  assign y_hi = (32'(in_i.pos_y) == CHUNK_TALL - 1);

  assign wr_code = CODE_BITS'(in_i.write_code);
  assign wr_ok   = acc_i && in_range;

  // Neighbor writes off the touching face are dropped.
  always_comb begin
    cen_we  = 1'b0;
    slc_we  = '0;
    query_o = 1'b0;
    case (in_i.opcode)
      OP_CENTRE: cen_we          = wr_ok;
      OP_NORTH:  slc_we[FACE_N]  = wr_ok && z_hi;
      OP_SOUTH:  slc_we[FACE_S]  = wr_ok && z_lo;
      OP_WEST:   slc_we[FACE_W]  = wr_ok && x_hi;
      OP_EAST:   slc_we[FACE_E]  = wr_ok && x_lo;
      OP_QUERY:  query_o         = wr_ok;
      default:   query_o         = 1'b0;
    endcase
  end

  assign cen_addr = {z, y, x};

  // Wrapped addresses at the edges read don't-care entries; side ones are muxed away below, y ones masked by y_lo/y_hi.
  assign cen_raddr[0]          = cen_addr;
  assign cen_raddr[1 + FACE_N] = {z - XW'(1), y, x};
  assign cen_raddr[1 + FACE_S] = {z + XW'(1), y, x};
  assign cen_raddr[1 + FACE_W] = {z, y, x - XW'(1)};
  assign cen_raddr[1 + FACE_E] = {z, y, x + XW'(1)};
  assign cen_raddr[1 + FACE_B] = {z, y - YW'(1), x};
  assign cen_raddr[1 + FACE_T] = {z, y + YW'(1), x};

  assign slc_addr[FACE_N] = {y, x};
  assign slc_addr[FACE_S] = {y, x};
  assign slc_addr[FACE_W] = {y, z};
  assign slc_addr[FACE_E] = {y, z};

  // Centre chunk held in one copy per read port; every copy takes each write.
  for (genvar g = 0; g < NUM_COPIES; g++) begin : g_cen
    vfv_ram #(.AW(CAW), .DW(CODE_BITS)) u_cen_ram (
      .clk_i   (clk_i),
      .we_i    (cen_we),
      .waddr_i (cen_addr),
      .wdata_i (wr_code),
      .re_i    (en_i),
      .raddr_i (cen_raddr[g]),
      .rdata_o (cen_rd[g])
    );
  end

  for (genvar g = 0; g < NUM_SIDES; g++) begin : g_slc
    vfv_ram #(.AW(SAW), .DW(CODE_BITS)) u_slc_ram (
      .clk_i   (clk_i),
      .we_i    (slc_we[g]),
      .waddr_i (slc_addr[g]),
      .wdata_i (wr_code),
      .re_i    (en_i),
      .raddr_i (slc_addr[g]),
      .rdata_o (slc_rd[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      edge_q <= {x_lo, x_hi, z_lo, z_hi, y_lo, y_hi};
    end
  end

  assign blk_code_o        = cen_rd[0];
  assign nb_code_o[FACE_N] = edge_q[3] ? slc_rd[FACE_N] : cen_rd[1 + FACE_N];
  assign nb_code_o[FACE_S] = edge_q[2] ? slc_rd[FACE_S] : cen_rd[1 + FACE_S];
  assign nb_code_o[FACE_W] = edge_q[5] ? slc_rd[FACE_W] : cen_rd[1 + FACE_W];
  assign nb_code_o[FACE_E] = edge_q[4] ? slc_rd[FACE_E] : cen_rd[1 + FACE_E];
  assign nb_code_o[FACE_B] = cen_rd[1 + FACE_B];
  assign nb_code_o[FACE_T] = cen_rd[1 + FACE_T];
  assign y_lo_o            = edge_q[1];
  assign y_hi_o            = edge_q[0];

endmodule

### src/vfv_classify.sv
// Stage 2: compares the voxel and its neighbors against the air and water codes.
// Depends on vfv_pkg.
module vfv_classify import vfv_pkg::*; #(
  parameter int unsigned CODE_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [CODE_BITS-1:0]                blk_code_i,
  input  logic [NUM_FACES-1:0][CODE_BITS-1:0] nb_code_i,
  input  logic                                y_lo_i,
  input  logic                                y_hi_i,
  input  logic [CODE_BITS-1:0]                air_i,
  input  logic [CODE_BITS-1:0]                water_i,
  output logic [CODE_BITS-1:0]                blk_code_o,
  output vfv_flags_t                          flags_o
);

  vfv_flags_t           flags_d, flags_q;
  logic [CODE_BITS-1:0] blk_code_q;

  always_comb begin
    for (int i = 0; i < NUM_FACES; i++) begin
      flags_d.nb_air[i]   = (nb_code_i[i] == air_i);
      flags_d.nb_water[i] = (nb_code_i[i] == water_i);
    end
    flags_d.bot_same = (nb_code_i[FACE_B] == blk_code_i);
    flags_d.top_same = (nb_code_i[FACE_T] == blk_code_i);
    flags_d.liquid   = (blk_code_i == water_i);
    flags_d.y_lo     = y_lo_i;
    flags_d.y_hi     = y_hi_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q    <= flags_d;
      blk_code_q <= blk_code_i;
    end
  end

  assign flags_o    = flags_q;
  assign blk_code_o = blk_code_q;

endmodule

### src/vfv_mask.sv
// Stage 3: face mask and liquid-on-top rules, into the output register.
// Depends on vfv_pkg.
module vfv_mask import vfv_pkg::*; #(
  parameter int unsigned CODE_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CODE_BITS-1:0] blk_code_i,
  input  vfv_flags_t           flags_i,
  output vfv_out_t             out_o
);

  vfv_out_t out_d, out_q;
  logic     liq;

  assign liq = flags_i.liquid;

  always_comb begin
    // Sides: water sees only air, anything else sees air or water.
    for (int i = 0; i < NUM_SIDES; i++) begin
      out_d.face_mask[i] = flags_i.nb_air[i] || (!liq && flags_i.nb_water[i]);
    end
    out_d.face_mask[FACE_B] = flags_i.y_lo ||
        (liq ? (!flags_i.bot_same && flags_i.nb_air[FACE_B])
             : (flags_i.nb_air[FACE_B] || flags_i.nb_water[FACE_B]));
    out_d.face_mask[FACE_T] = flags_i.y_hi ||
        (liq ? !flags_i.top_same
             : (flags_i.nb_air[FACE_T] || flags_i.nb_water[FACE_T]));
    out_d.liquid_on_top = !flags_i.y_hi && liq && flags_i.top_same;
    out_d.is_liquid     = liq;
    out_d.voxel_code    = FLD_CODE_W'(blk_code_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

### src/voxel_face_visibility_mask_unit.sv
// Top level of the voxel face visibility mask unit: handshake, config registers.
// Depends on vfv_pkg, vfv_fetch, vfv_classify, vfv_mask.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i) carries load and query
//    transactions. Loads write one voxel of the centre chunk or one boundary
//    voxel of a side neighbor and give no result. A query in range gives one.
//  - Output channel (out_valid_o/out_ready_i/out_data_o) returns code, liquid
//    flag, six-bit face mask and liquid-on-top flag per query, in order.
//  - Config port (cfg_we_i/cfg_idx_i/cfg_wdata_i) sets the air and water
//    codes; write only while no transaction is in flight.
//  - Throughput: one transaction per cycle unless out_ready_i stalls the pipe.
//    Every query reads seven centre voxels from seven store copies, one read
//    port each, so the read stage takes a new query every cycle.
//  - Pipeline: a query's result is registered in the RAM read, compare and
//    mask/output registers in that order before it can leave. A load is
//    written at its accept edge and seen by a query accepted in the next
//    cycle.
//  - Stall: each stage loads when it is empty or the stage after it loads, so
//    bubbles collapse and input is still taken while a result waits.
//  - Reset clears valid bits and sets air = 0, water = 1. Voxel stores are
//    not cleared; a voxel must be written before a query reads it.
module voxel_face_visibility_mask_unit import vfv_pkg::*; #(
  parameter int unsigned CHUNK_SIDE = 16,
  parameter int unsigned CHUNK_TALL = 256,
  parameter int unsigned CODE_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vfv_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output vfv_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [CODE_BITS-1:0] air_q, water_q;

  // Stage valids: v1 = RAM read data, v2 = compare flags, v3 = output register.
  logic v1_q, v2_q, v3_q;
  logic v1_d;
  logic en1, en2, en3;
  logic acc;

  logic [CODE_BITS-1:0]                s1_blk;
  logic [NUM_FACES-1:0][CODE_BITS-1:0] s1_nb;
  logic                                s1_y_lo, s1_y_hi;
  logic [CODE_BITS-1:0]                s2_blk;
  vfv_flags_t                          s2_flags;

  // Config registers, kept to the low CODE_BITS bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_q   <= '0;
      water_q <= CODE_BITS'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_AIR) begin
        air_q <= CODE_BITS'(cfg_wdata_i);
      end
      if (cfg_idx_i == CFG_WATER) begin
        water_q <= CODE_BITS'(cfg_wdata_i);
      end
    end
  end

  // Per-stage load enables; a stage advances into an empty or draining slot.
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign acc        = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= v1_d;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  vfv_fetch #(
    .CHUNK_SIDE (CHUNK_SIDE),
    .CHUNK_TALL (CHUNK_TALL),
    .CODE_BITS  (CODE_BITS)
  ) u_fetch (
    .clk_i      (clk_i),
    .en_i       (en1),
    .acc_i      (acc),
    .in_i       (in_data_i),
    .query_o    (v1_d),
    .blk_code_o (s1_blk),
    .nb_code_o  (s1_nb),
    .y_lo_o     (s1_y_lo),
    .y_hi_o     (s1_y_hi)
  );

  vfv_classify #(.CODE_BITS(CODE_BITS)) u_classify (
    .clk_i      (clk_i),
    .en_i       (en2),
    .blk_code_i (s1_blk),
    .nb_code_i  (s1_nb),
    .y_lo_i     (s1_y_lo),
    .y_hi_i     (s1_y_hi),
    .air_i      (air_q),
    .water_i    (water_q),
    .blk_code_o (s2_blk),
    .flags_o    (s2_flags)
  );

  vfv_mask #(.CODE_BITS(CODE_BITS)) u_mask (
    .clk_i      (clk_i),
    .en_i       (en3),
    .blk_code_i (s2_blk),
    .flags_i    (s2_flags),
    .out_o      (out_data_o)
  );

  assign out_valid_o = v3_q;

`ifndef NO_ASSERTIONS
  // An empty output register must let the whole pipe move.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  // Loads and bad opcodes never create a result.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (in_data_i.opcode != OP_QUERY)) |=> !v1_q)
    else $error("non-query transaction entered the pipe");

  // A stalled full pipe keeps its middle stage.
  a_stage2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && v3_q && !out_ready_i) |=> v2_q)
    else $error("stage 2 item lost during stall");

  // Liquid on top only for water, and then the top face is hidden.
  a_on_top_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && out_data_o.liquid_on_top) |->
      (out_data_o.is_liquid && !out_data_o.face_mask[FACE_T]))
    else $error("liquid_on_top with inconsistent flags");
`endif

endmodule
